>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk with reset arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define CHK_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CHK_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bbsp_pkg.sv
// ---------------------------------------------------------------------------
// bbsp_pkg
// Types, constants and the arctangent table of the sprite projector.
// ---------------------------------------------------------------------------
`default_nettype none

package bbsp_pkg;

	localparam int POS_W      = 22;
	localparam int HEAD_W     = 16;
	localparam int FRAME_W    = 3;
	localparam int CFG_DATA_W = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CODE_W     = 8;
	localparam int LEFT_W     = 13;
	localparam int TOP_W      = 12;
	localparam int SIZE_W     = 12;
	localparam int ANG_W      = 24;
	localparam int CORDIC_STEPS = 16;

	localparam logic [CODE_W-1:0] FIRE_CODE = 8'h33;
	localparam int HALF_FOV_STEPS = 10922;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X   = 2'd0,
		REG_POS_Y   = 2'd1,
		REG_HEADING = 2'd2,
		REG_FRAME   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [LEFT_W-1:0] left;
		logic signed [TOP_W-1:0]  top;
		logic [SIZE_W-1:0]        size;
		logic [FRAME_W-1:0]       frame;
	} result_t;

	// atan(2^-i) in units of 2^-24 turn.
	function automatic logic [ANG_W-1:0] atan_entry(input int i);
		logic [ANG_W-1:0] r;
		case (i)
			0: r = 24'd2097152;
			1: r = 24'd1238021;
			2: r = 24'd654136;
			3: r = 24'd332050;
			4: r = 24'd166669;
			5: r = 24'd83416;
			6: r = 24'd41718;
			7: r = 24'd20860;
			8: r = 24'd10430;
			9: r = 24'd5215;
			10: r = 24'd2608;
			11: r = 24'd1304;
			12: r = 24'd652;
			13: r = 24'd326;
			14: r = 24'd163;
			15: r = 24'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/bbsp_cordic.sv
// ---------------------------------------------------------------------------
// bbsp_cordic
// Sixteen-stage vectoring CORDIC; one stage per step, side data rides along.
// ---------------------------------------------------------------------------
`default_nettype none

module bbsp_cordic #(
	parameter int XW     = 31,
	parameter int SIDE_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [XW-1:0]          x_in,
	input  wire logic signed [XW-1:0]          y_in,
	input  wire logic [bbsp_pkg::ANG_W-1:0]    z_in,
	input  wire logic [SIDE_W-1:0]             side_in,
	output logic                               out_valid,
	output logic [bbsp_pkg::ANG_W-1:0]         z_out,
	output logic [SIDE_W-1:0]                  side_out
);
	import bbsp_pkg::*;

	logic                    vld_sn  [0:CORDIC_STEPS];
	logic signed [XW-1:0]    x_sn    [0:CORDIC_STEPS];
	logic signed [XW-1:0]    y_sn    [0:CORDIC_STEPS];
	logic [ANG_W-1:0]        z_sn    [0:CORDIC_STEPS];
	logic [SIDE_W-1:0]       side_sn [0:CORDIC_STEPS];

	assign vld_sn[0]  = in_valid;
	assign x_sn[0]    = x_in;
	assign y_sn[0]    = y_in;
	assign z_sn[0]    = z_in;
	assign side_sn[0] = side_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XW-1:0] xsh, ysh, xn, yn;
		logic [ANG_W-1:0]     zn;

		// Rotate toward the x axis; the sign of y picks the direction.
		always_comb begin
			xsh = x_sn[i] >>> i;
			ysh = y_sn[i] >>> i;
			if (!y_sn[i][XW-1]) begin
				xn = x_sn[i] + ysh;
				yn = y_sn[i] - xsh;
				zn = z_sn[i] + atan_entry(i);
			end else begin
				xn = x_sn[i] - ysh;
				yn = y_sn[i] + xsh;
				zn = z_sn[i] - atan_entry(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[i+1] <= 1'b0;
			end else if (en) begin
				vld_sn[i+1] <= vld_sn[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_sn[i+1]    <= xn;
				y_sn[i+1]    <= yn;
				z_sn[i+1]    <= zn;
				side_sn[i+1] <= side_sn[i];
			end
		end
	end

	assign out_valid = vld_sn[CORDIC_STEPS];
	assign z_out     = z_sn[CORDIC_STEPS];
	assign side_out  = side_sn[CORDIC_STEPS];

endmodule

`default_nettype wire

>>> hdl/bbsp_isqrt.sv
// ---------------------------------------------------------------------------
// bbsp_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bbsp_isqrt #(
	parameter int RW     = 23,
	parameter int SIDE_W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [2*RW-1:0]      v_in,
	input  wire logic [SIDE_W-1:0]    side_in,
	output logic                      out_valid,
	output logic [RW-1:0]             root_out,
	output logic [SIDE_W-1:0]         side_out
);
	localparam int TW = 2 * RW + 1;

	logic              vld_sn  [0:RW];
	logic [TW-1:0]     rem_sn  [0:RW];
	logic [RW-1:0]     root_sn [0:RW];
	logic [SIDE_W-1:0] side_sn [0:RW];

	assign vld_sn[0]  = in_valid;
	assign rem_sn[0]  = TW'(v_in);
	assign root_sn[0] = '0;
	assign side_sn[0] = side_in;

	for (genvar j = 0; j < RW; j++) begin : g_bit
		localparam int BI = RW - 1 - j;
		logic [TW-1:0] trial, rem_n;
		logic [RW-1:0] root_n;

		// (Q + 2^b)^2 - Q^2 = 2^(b+1) Q + 2^(2b)
		always_comb begin
			trial  = (TW'(root_sn[j]) << (BI + 1)) | (TW'(1) << (2 * BI));
			rem_n  = rem_sn[j];
			root_n = root_sn[j];
			if (rem_sn[j] >= trial) begin
				rem_n      = rem_sn[j] - trial;
				root_n[BI] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[j+1] <= 1'b0;
			end else if (en) begin
				vld_sn[j+1] <= vld_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sn[j+1]  <= rem_n;
				root_sn[j+1] <= root_n;
				side_sn[j+1] <= side_sn[j];
			end
		end
	end

	assign out_valid = vld_sn[RW];
	assign root_out  = root_sn[RW];
	assign side_out  = side_sn[RW];

endmodule

`default_nettype wire

>>> hdl/billboard_sprite_projector.sv
// Billboard sprite projector: takes one map cell per request and, for a fire
// cell that lies within sixty degrees of the player heading, returns the
// screen rectangle (left, top, square size) and the animation frame to draw.
// Other cells produce no result. The block is a fully pipelined datapath that
// accepts one cell every clock cycle while input ready is high. A cell passes
// through the offset, magnitude, square and squared-distance stages, the
// 16-stage CORDIC for the bearing, the bit-per-stage square root for the
// distance, the bit-per-stage divider for the size, and a saturation stage.
// Results land in a two-entry output buffer, so a new cell is taken while a
// finished result waits; input ready drops only when that buffer is full and
// the consumer is not taking a result. Configuration registers must only be
// written while no cell is in flight.
// ---------------------------------------------------------------------------
// billboard_sprite_projector
// Projects fire cells of the map onto the screen as billboard sprites.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module billboard_sprite_projector #(
	parameter int SCREEN_WIDTH    = 1024,
	parameter int SCREEN_HEIGHT   = 768,
	parameter int CELL_UNITS      = 64,
	parameter int MAX_SPRITE_SIZE = 4095
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [bbsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bbsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [bbsp_pkg::CODE_W-1:0]          cell_col,
	input  wire logic [bbsp_pkg::CODE_W-1:0]          cell_row,
	input  wire logic [bbsp_pkg::CODE_W-1:0]          cell_code,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [bbsp_pkg::LEFT_W-1:0]        sprite_left,
	output logic signed [bbsp_pkg::TOP_W-1:0]         sprite_top,
	output logic [bbsp_pkg::SIZE_W-1:0]               sprite_size,
	output logic [bbsp_pkg::FRAME_W-1:0]              frame_index
);
	import bbsp_pkg::*;

	// Cell center times 256 stays below CELL_UNITS * 2^16.
	localparam int CTR_W = $clog2(CELL_UNITS) + 16;
	localparam int MW    = (CTR_W > POS_W) ? CTR_W : POS_W;
	localparam int DW    = MW + 1;
	localparam int SQ_W  = 2 * MW;
	localparam int SUM_W = 2 * MW + 1;
	localparam int XW    = MW + 9;
	localparam int RW    = MW + 1;
	localparam longint NUM = 64'(50) * 64'(SCREEN_HEIGHT) * 64'(256);
	localparam int NW    = $clog2(NUM + 1);
	localparam int QB    = $clog2(MAX_SPRITE_SIZE + 1);
	localparam int CW    = ((NW > RW + QB) ? NW : RW + QB) + 1;
	localparam int PRW   = 34;
	localparam int SIX_W = 6 * SCREEN_WIDTH;
	localparam int X_OFS = SCREEN_WIDTH * 32768;
	localparam int TD_W  = 15;

	// ---------------- configuration registers ----------------
	logic [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [HEAD_W-1:0]  heading_q;
	logic [FRAME_W-1:0] frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			heading_q <= '0;
			frame_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data[POS_W-1:0];
				REG_POS_Y:   pos_y_q   <= cfg_data[POS_W-1:0];
				REG_HEADING: heading_q <= cfg_data[HEAD_W-1:0];
				REG_FRAME:   frame_q   <= cfg_data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// All stages advance together; the output buffer decides when.
	logic [1:0] count_q;
	logic       en, push, pop;

	assign en       = (count_q != 2'd2) || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: offsets from the player ----------------
	logic [CTR_W-1:0]     cx, cy;
	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	assign cx = CTR_W'((32'(cell_col) * CELL_UNITS + CELL_UNITS / 2) * 256);
	assign cy = CTR_W'((32'(cell_row) * CELL_UNITS + CELL_UNITS / 2) * 256);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			// Only fire cells travel on; everything else becomes a bubble.
			vld_s1 <= in_valid && (cell_code == FIRE_CODE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed(DW'(cx)) - $signed(DW'(pos_x_q));
			dy_s1 <= $signed(DW'(cy)) - $signed(DW'(pos_y_q));
		end
	end

	// ---------------- stage 2: magnitudes and CORDIC pre-rotation ----------------
	logic                 vld_s2, zero_s2;
	logic [MW-1:0]        ax_s2, ay_s2;
	logic signed [XW-1:0] x0_s2, y0_s2;
	logic [ANG_W-1:0]     z0_s2;
	logic signed [XW-1:0] dxe, dye;

	assign dxe = XW'(dx_s1);
	assign dye = XW'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= dx_s1[DW-1] ? MW'(-dx_s1) : MW'(dx_s1);
			ay_s2   <= dy_s1[DW-1] ? MW'(-dy_s1) : MW'(dy_s1);
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			// Left half plane: turn by half a turn so CORDIC converges.
			if (dx_s1[DW-1]) begin
				x0_s2 <= (-dxe) <<< 6;
				y0_s2 <= (-dye) <<< 6;
				z0_s2 <= 24'h800000;
			end else begin
				x0_s2 <= dxe <<< 6;
				y0_s2 <= dye <<< 6;
				z0_s2 <= '0;
			end
		end
	end

	// ---------------- stage 3: squares ----------------
	logic                 vld_s3, zero_s3;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;
	logic signed [XW-1:0] x0_s3, y0_s3;
	logic [ANG_W-1:0]     z0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			sqy_s3  <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
			zero_s3 <= zero_s2;
			x0_s3   <= x0_s2;
			y0_s3   <= y0_s2;
			z0_s3   <= z0_s2;
		end
	end

	// ---------------- stage 4: squared distance ----------------
	logic                 vld_s4, zero_s4;
	logic [SUM_W-1:0]     sum_s4;
	logic signed [XW-1:0] x0_s4, y0_s4;
	logic [ANG_W-1:0]     z0_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4  <= SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
			zero_s4 <= zero_s3;
			x0_s4   <= x0_s3;
			y0_s4   <= y0_s3;
			z0_s4   <= z0_s3;
		end
	end

	// ---------------- CORDIC: bearing of the cell ----------------
	logic                   cor_valid;
	logic [ANG_W-1:0]       cor_z;
	logic [SUM_W:0]         cor_side;

	bbsp_cordic #(
		.XW     (XW),
		.SIDE_W (SUM_W + 1)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s4),
		.x_in      (x0_s4),
		.y_in      (y0_s4),
		.z_in      (z0_s4),
		.side_in   ({zero_s4, sum_s4}),
		.out_valid (cor_valid),
		.z_out     (cor_z),
		.side_out  (cor_side)
	);

	// Round the angle to 16 bits and take it relative to the heading. A
	// player standing on the cell center sees angle zero.
	logic [ANG_W-1:0]  z_rnd;
	logic [HEAD_W-1:0] bearing;
	logic signed [HEAD_W-1:0] bearing_s;
	logic              in_fov;

	assign z_rnd     = (cor_side[SUM_W] ? '0 : cor_z) + ANG_W'(128);
	assign bearing   = z_rnd[ANG_W-1:8] - heading_q;
	assign bearing_s = $signed(bearing);
	assign in_fov    = (bearing_s <= HEAD_W'(HALF_FOV_STEPS))
			&& (bearing_s >= -HEAD_W'(HALF_FOV_STEPS));

	// ---------------- square root: distance ----------------
	logic              sq_valid;
	logic [RW-1:0]     dist_root;
	logic [HEAD_W-1:0] sq_bearing;

	bbsp_isqrt #(
		.RW     (RW),
		.SIDE_W (HEAD_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cor_valid && in_fov),
		.v_in      ((2 * RW)'(cor_side[SUM_W-1:0])),
		.side_in   (bearing),
		.out_valid (sq_valid),
		.root_out  (dist_root),
		.side_out  (sq_bearing)
	);

	// ---------------- divider: size = 50 * H * 256 / dist_root ----------------
	// Stage 0 flags a quotient too large for QB bits (a zero distance
	// included), then one quotient bit per stage.
	logic              vld_dv  [0:QB];
	logic [CW-1:0]     rem_dv  [0:QB];
	logic [RW-1:0]     d_dv    [0:QB];
	logic [QB-1:0]     q_dv    [0:QB];
	logic              over_dv [0:QB];
	logic [HEAD_W-1:0] b_dv    [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv[0] <= 1'b0;
		end else if (en) begin
			vld_dv[0] <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_dv[0]  <= CW'(NUM);
			d_dv[0]    <= dist_root;
			q_dv[0]    <= '0;
			over_dv[0] <= CW'(NUM >> QB) >= CW'(dist_root);
			b_dv[0]    <= sq_bearing;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int BI = QB - 1 - j;
		logic [CW-1:0] trial, rem_n;
		logic [QB-1:0] q_n;

		always_comb begin
			trial = CW'(d_dv[j]) << BI;
			rem_n = rem_dv[j];
			q_n   = q_dv[j];
			if (rem_dv[j] >= trial) begin
				rem_n  = rem_dv[j] - trial;
				q_n[BI] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[j+1] <= 1'b0;
			end else if (en) begin
				vld_dv[j+1] <= vld_dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_dv[j+1]  <= rem_n;
				d_dv[j+1]    <= d_dv[j];
				q_dv[j+1]    <= q_n;
				over_dv[j+1] <= over_dv[j];
				b_dv[j+1]    <= b_dv[j];
			end
		end
	end

	// ---------------- final stage 1: saturate and scale the bearing ----------------
	logic                  vld_f1;
	logic [QB-1:0]         size_f1;
	logic signed [PRW-1:0] prod_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else if (en) begin
			vld_f1 <= vld_dv[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (over_dv[QB] || (q_dv[QB] > QB'(MAX_SPRITE_SIZE))) begin
				size_f1 <= QB'(MAX_SPRITE_SIZE);
			end else begin
				size_f1 <= q_dv[QB];
			end
			prod_f1 <= PRW'($signed(b_dv[QB])) * PRW'(SIX_W);
		end
	end

	// ---------------- final stage 2: rectangle, into the output buffer ----------------
	logic signed [PRW-1:0]  num_x, sx;
	logic signed [TD_W-1:0] top_d, top_v;
	result_t                res_n;

	always_comb begin
		num_x = prod_f1 + PRW'(X_OFS);
		// Division by 65536 truncating toward zero.
		sx    = (num_x + (num_x[PRW-1] ? PRW'(65535) : PRW'(0))) >>> 16;
		top_d = TD_W'(SCREEN_HEIGHT) - $signed(TD_W'(size_f1));
		top_v = (top_d + (top_d[TD_W-1] ? TD_W'(1) : TD_W'(0))) >>> 1;
		res_n.left  = LEFT_W'(sx - PRW'(size_f1 >> 1));
		res_n.top   = TOP_W'(top_v);
		res_n.size  = SIZE_W'(size_f1);
		res_n.frame = frame_q;
	end

	// ---------------- two-entry output buffer ----------------
	result_t buf0_q, buf1_q;

	assign push = en && vld_f1;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (count_q == 2'd2)) begin
			buf0_q <= buf1_q;
		end
		if (push) begin
			if ((count_q == 2'd0) || ((count_q == 2'd1) && pop)) begin
				buf0_q <= res_n;
			end else begin
				buf1_q <= res_n;
			end
		end
	end

	assign out_valid   = (count_q != 2'd0);
	assign sprite_left = buf0_q.left;
	assign sprite_top  = buf0_q.top;
	assign sprite_size = buf0_q.size;
	assign frame_index = buf0_q.frame;

	// ---------------- assertions ----------------
	`CHK_RST(a_count_range, count_q != 2'd3, "output buffer count out of range")
	`CHK_RST(a_no_overflow, (push && (count_q == 2'd2)) |-> pop, "push into a full output buffer")
	`CHK_RST(a_size_sat, vld_f1 |-> (size_f1 <= QB'(MAX_SPRITE_SIZE)), "size above saturation")
	`CHK_RST(a_drop_other, (in_valid && in_ready && (cell_code != FIRE_CODE)) |=> !vld_s1, "non-fire cell entered the pipeline")

endmodule

`default_nettype wire

>>> dv/billboard_sprite_projector_tb.sv
// ---------------------------------------------------------------------------
// billboard_sprite_projector_tb
// Self-checking bench for the sprite projector. It sends map cells in valid
// and ready requests, computes the expected sprite rectangle of each fire
// cell in view with its own integer projection model, and compares every
// returned sprite field by field. Configuration changes between phases, once
// the block is idle. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module billboard_sprite_projector_tb;
	import bbsp_pkg::*;

	localparam int SCR_W      = 1024;
	localparam int SCR_H      = 768;
	localparam int CELL_SZ    = 64;
	localparam int SIZE_LIMIT = 4095;
	// The margin covers the time that a cell spends in the pipeline.
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [CODE_W-1:0] col;
		logic [CODE_W-1:0] row;
		logic [CODE_W-1:0] code;
	} cell_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CODE_W-1:0] cell_col;
	logic [CODE_W-1:0] cell_row;
	logic [CODE_W-1:0] cell_code;
	logic out_valid;
	logic out_ready;
	logic signed [LEFT_W-1:0] sprite_left;
	logic signed [TOP_W-1:0] sprite_top;
	logic [SIZE_W-1:0] sprite_size;
	logic [FRAME_W-1:0] frame_index;

	// The bench keeps its own copy of the configuration registers.
	logic [POS_W-1:0] view_x;
	logic [POS_W-1:0] view_y;
	logic [HEAD_W-1:0] view_heading;
	logic [FRAME_W-1:0] view_frame;

	cell_t cells_to_send[$];
	result_t sprites_due[$];
	int mismatches;
	bit steady_flow;    // no idling on either side while set
	bit hold_request;   // asks the receiver for one long hold-off
	bit hold_done;
	int hold_left;

	billboard_sprite_projector dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cell_col(cell_col),
		.cell_row(cell_row),
		.cell_code(cell_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sprite_left(sprite_left),
		.sprite_top(sprite_top),
		.sprite_size(sprite_size),
		.frame_index(frame_index)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Exact integer square root, bit by bit.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Bearing of the offset as a 16-bit binary angle, from a 16-step
	// vectoring CORDIC. The left half plane is folded by a half turn first.
	function automatic logic [15:0] bearing_of(input longint dx, input longint dy);
		longint x;
		longint y;
		longint xs;
		longint ys;
		logic [ANG_W-1:0] z;
		logic [ANG_W-1:0] zr;
		logic [ANG_W-1:0] step_ang [CORDIC_STEPS] = '{
			24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669,
			24'd83416, 24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608,
			24'd1304, 24'd652, 24'd326, 24'd163, 24'd81};
		x = dx * 64;
		y = dy * 64;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 24'h800000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + step_ang[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - step_ang[i];
			end
		end
		zr = z + 24'd128;
		return zr[23:8];
	endfunction

	// Projects one cell against the current view. Returns 0 when the cell
	// draws nothing: not a fire cell, or outside the sixty-degree half field.
	function automatic bit project_cell(input cell_t c, output result_t s);
		longint dx;
		longint dy;
		longint unsigned dist_root;
		logic [15:0] ang;
		logic [15:0] rel;
		longint b;
		longint sz;
		longint cx;
		longint lft;
		longint tp;
		s = '0;
		if (c.code != FIRE_CODE)
			return 0;
		dx = (longint'(c.col) * CELL_SZ + CELL_SZ / 2) * 256 - longint'(view_x);
		dy = (longint'(c.row) * CELL_SZ + CELL_SZ / 2) * 256 - longint'(view_y);
		dist_root = int_sqrt(longint'(dx * dx + dy * dy));
		// Player standing on the cell center: the angle is taken as zero.
		ang = (dx == 0 && dy == 0) ? 16'd0 : bearing_of(dx, dy);
		rel = ang - view_heading;
		b = longint'($signed(rel));
		if (b > HALF_FOV_STEPS || b < -HALF_FOV_STEPS)
			return 0;
		if (dist_root == 0)
			sz = SIZE_LIMIT;
		else begin
			sz = longint'((64'd50 * SCR_H * 256) / dist_root);
			if (sz > SIZE_LIMIT)
				sz = SIZE_LIMIT;
		end
		cx = (longint'(SCR_W) * 32768 + 6 * longint'(SCR_W) * b) / 65536;
		lft = cx - sz / 2;
		tp = (longint'(SCR_H) - sz) / 2;
		s.left = lft[LEFT_W-1:0];
		s.top = tp[TOP_W-1:0];
		s.size = sz[SIZE_W-1:0];
		s.frame = view_frame;
		return 1;
	endfunction

	task automatic report_mismatch(input string field, input longint got,
			input longint want);
		$display("%0t: %s is %0d, expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	// Sender: a request stays on the bus until the block takes it. A new
	// cell is offered only after the previous one went through.
	always @(posedge clk or negedge arst_n) begin
		cell_t nxt;
		result_t spr;
		bit offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cell_col <= '0;
			cell_row <= '0;
			cell_code <= '0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				if (project_cell('{cell_col, cell_row, cell_code}, spr))
					sprites_due.push_back(spr);
				offer = 1'b0;
			end
			if (!offer && cells_to_send.size() > 0 &&
					(steady_flow || $urandom_range(99) >= 34)) begin
				nxt = cells_to_send.pop_front();
				cell_col <= nxt.col;
				cell_row <= nxt.row;
				cell_code <= nxt.code;
				offer = 1'b1;
			end
			in_valid <= offer;
		end
	end

	// Receiver: checks every returned sprite against the oldest one due,
	// and stalls at random. One long hold-off lets the pipeline fill up.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (sprites_due.size() == 0) begin
					report_mismatch("unexpected sprite count", 1, 0);
				end else begin
					want = sprites_due.pop_front();
					if (sprite_left !== want.left)
						report_mismatch("sprite_left", sprite_left, want.left);
					if (sprite_top !== want.top)
						report_mismatch("sprite_top", sprite_top, want.top);
					if (sprite_size !== want.size)
						report_mismatch("sprite_size", sprite_size, want.size);
					if (frame_index !== want.frame)
						report_mismatch("frame_index", frame_index, want.frame);
				end
			end
			if (hold_request && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_flow || $urandom_range(99) >= 34;
			end
		end
	end

	task automatic wait_idle();
		while (cells_to_send.size() > 0 || in_valid || sprites_due.size() > 0)
			@(posedge clk);
		// Cells that draw nothing may still be in the pipeline.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_POS_X: view_x = val[POS_W-1:0];
			REG_POS_Y: view_y = val[POS_W-1:0];
			REG_HEADING: view_heading = val[HEAD_W-1:0];
			REG_FRAME: view_frame = val[FRAME_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_view(input logic [CFG_DATA_W-1:0] px,
			input logic [CFG_DATA_W-1:0] py, input logic [15:0] hd,
			input logic [2:0] fr);
		wait_idle();
		write_reg(REG_POS_X, px);
		write_reg(REG_POS_Y, py);
		write_reg(REG_HEADING, {6'd0, hd});
		write_reg(REG_FRAME, {19'd0, fr});
	endtask

	task automatic add_cell(input int col, input int row, input int code);
		cells_to_send.push_back('{col[7:0], row[7:0], code[7:0]});
	endtask

	// Mostly fire cells near the player so that many land in view, with
	// some cells anywhere on the map and some other codes as noise.
	task automatic add_random_cells(input int count);
		int pc;
		int pr;
		int col;
		int row;
		int code;
		pc = view_x >> 14;
		pr = view_y >> 14;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 70) begin
				col = pc + $signed($urandom_range(20)) - 10;
				row = pr + $signed($urandom_range(20)) - 10;
				if (col < 0) col = 0;
				if (col > 255) col = 255;
				if (row < 0) row = 0;
				if (row > 255) row = 255;
			end else begin
				col = $urandom_range(255);
				row = $urandom_range(255);
			end
			code = ($urandom_range(99) < 75) ? FIRE_CODE : $urandom_range(255);
			add_cell(col, row, code);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_POS_X;
		cfg_data = '0;
		view_x = '0;
		view_y = '0;
		view_heading = '0;
		view_frame = '0;
		mismatches = 0;
		steady_flow = 1'b0;
		hold_request = 1'b0;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// Directed: reset view, player in the map corner, looking along +x.
		add_cell(0, 0, FIRE_CODE);
		add_cell(5, 0, FIRE_CODE);
		add_cell(255, 0, FIRE_CODE);
		add_cell(255, 255, FIRE_CODE);
		add_cell(0, 255, FIRE_CODE);
		add_cell(5, 0, 8'h32);
		add_cell(5, 0, 8'h34);
		add_cell(5, 0, 8'hCC);
		add_cell(5, 0, 8'h00);
		add_cell(5, 0, 8'hFF);
		// Player exactly on the center of cell (10, 20): zero distance.
		set_view(22'd172032, 22'd335872, 16'd0, 3'd4);
		add_cell(10, 20, FIRE_CODE);
		add_cell(11, 20, FIRE_CODE);
		add_cell(9, 20, FIRE_CODE);
		add_cell(10, 21, FIRE_CODE);
		add_cell(10, 19, FIRE_CODE);
		// Far corner, facing back; frame code at the top of its 3-bit range.
		set_view(22'h3FFFFF, 22'h3FFFFF, 16'hFFFF, 3'd7);
		add_cell(0, 0, FIRE_CODE);
		add_cell(255, 255, FIRE_CODE);
		add_cell(254, 255, FIRE_CODE);
		add_cell(0, 255, FIRE_CODE);
		// Center of the map, facing half a turn: directly behind is -32768.
		set_view(22'h200000, 22'h200000, 16'h8000, 3'd1);
		add_cell(120, 128, FIRE_CODE);
		add_cell(136, 128, FIRE_CODE);
		add_cell(128, 120, FIRE_CODE);
		add_cell(128, 136, FIRE_CODE);

		for (int ph = 0; ph < 12; ph++) begin
			set_view(CFG_DATA_W'($urandom_range(22'h3FFFFF)),
				CFG_DATA_W'($urandom_range(22'h3FFFFF)),
				16'($urandom_range(16'hFFFF)), 3'($urandom_range(7)));
			// One phase runs without idling, one with a long receiver hold.
			steady_flow = (ph == 4);
			if (ph == 7)
				hold_request = 1'b1;
			add_random_cells(150);
		end
		wait_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
